// ===== hw/rtl/srd8_pkg.sv =====
// Shared constants and item types for the stick radial dead zone block.
package srd8_pkg;

  localparam int AXIS_BITS = 16;
  localparam int DZ_W      = AXIS_BITS - 1;
  localparam int MAG_W     = AXIS_BITS;
  localparam int SQ_W      = 2 * AXIS_BITS;
  localparam int ROOT_W    = AXIS_BITS;
  localparam int REM_W     = ROOT_W + 2;
  localparam int MA_W      = 2 * AXIS_BITS - 2;
  localparam int DENF_W    = AXIS_BITS;
  localparam int DEN_W     = ROOT_W + DENF_W;
  localparam int NUM_W     = MA_W + ROOT_W;
  localparam int QUO_W     = AXIS_BITS + 1;
  localparam int SLOPE_W   = 15;

  localparam int SQRT_STAGES = (ROOT_W + 1) / 2;
  localparam int DIV_STAGES  = (QUO_W + 1) / 2;
  localparam int LATENCY     = SQRT_STAGES + DIV_STAGES + 5;

  localparam logic [SLOPE_W-1:0]   SLOPE_Q16 = SLOPE_W'(27146);
  localparam logic [DZ_W-1:0]      DZ_RESET  = DZ_W'(8000);
  localparam logic [AXIS_BITS-1:0] AXIS_MAX  = {1'b0, {(AXIS_BITS-1){1'b1}}};
  localparam logic [DENF_W-1:0]    DENF_BASE = DENF_W'(2 ** (AXIS_BITS - 1) + 1);

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] axis_x;
    logic signed [AXIS_BITS-1:0] axis_y;
  } in_t;

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] scaled_x;
    logic signed [AXIS_BITS-1:0] scaled_y;
    logic                        outside_zone;
    logic                        dir_up;
    logic                        dir_down;
    logic                        dir_left;
    logic                        dir_right;
  } out_t;

endpackage

// ===== hw/rtl/stick_radial_deadzone_8way.sv =====
// Top level: pipelined radial dead zone, rescaling and eight-way direction for one stick.
// One item enters per clock and its result appears on result_o together with valid_o;
// busy_o stays low, so items may stream every cycle.
// The pipeline holds the magnitude square root (two root bits per stage, eight
// stages) and the two per-axis restoring dividers (two quotient bits per stage, nine
// stages), plus squaring, scale-factor multiply and output registers. The receiver
// cannot stall: each result is shown for exactly one cycle. Write dead_zone through
// cfg_we_i/cfg_wdata_i only while no item is in flight.
module stick_radial_deadzone_8way (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  srd8_pkg::in_t           item_i,
  output logic                    valid_o,
  output srd8_pkg::out_t          result_o,
  input  logic                    cfg_we_i,
  input  logic [srd8_pkg::DZ_W-1:0] cfg_wdata_i
);
  import srd8_pkg::*;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } dir_t;

  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    dir_t             dir;
  } side_t;

  typedef struct packed {
    logic outside;
    logic zero;
    logic neg_x;
    logic neg_y;
    dir_t dir;
  } flags_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [1:0] pair);
    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    sqrt_t            nxt;
    shifted = {cur.rem, pair};
    trial   = {2'b00, cur.root, 2'b01};
    if (shifted >= trial) begin
      nxt.rem  = REM_W'(shifted - trial);
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = shifted[REM_W-1:0];
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                              input logic nbit,
                                              input logic [DEN_W-1:0] den);
    logic [DEN_W:0] shifted;
    logic [DEN_W:0] res;
    shifted = {rem, nbit};
    if (shifted >= {1'b0, den}) begin
      res = {1'b1, DEN_W'(shifted - {1'b0, den})};
    end else begin
      res = {1'b0, shifted[DEN_W-1:0]};
    end
    return res;
  endfunction

  function automatic logic [AXIS_BITS-1:0] sat_axis(input logic neg, input logic ovf,
                                                    input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0]     mag;
    logic [AXIS_BITS-1:0] res;
    mag = ovf ? '1 : q;
    if (!neg) begin
      res = (mag > QUO_W'(AXIS_MAX)) ? AXIS_MAX : mag[AXIS_BITS-1:0];
    end else if (mag > QUO_W'(AXIS_MAX) + QUO_W'(1)) begin
      res = ~AXIS_MAX;
    end else begin
      res = ~mag[AXIS_BITS-1:0] + 1'b1;
    end
    return res;
  endfunction

  logic [DZ_W-1:0] dz_q;

  logic [SQRT_STAGES:0] sq_v_q;
  logic [DIV_STAGES:0]  dv_v_q;
  logic                 s1_v_q;
  logic                 s11_v_q;
  logic                 out_v_q;

  side_t            s1_side_q, side_d;
  logic [SQ_W-1:0]  s1_sqx_q, s1_sqy_q, sqx_d, sqy_d;

  logic [SQ_W-1:0] sq_n_q    [0:SQRT_STAGES-1];
  side_t           sq_side_q [0:SQRT_STAGES];
  sqrt_t           sq_st_q   [1:SQRT_STAGES];
  sqrt_t           sq_st_d   [0:SQRT_STAGES-1];

  logic [ROOT_W-1:0] s11_diff_q, diff_d;
  logic [DEN_W-1:0]  s11_den_q, den_d;
  logic [MA_W-1:0]   s11_max_q, s11_may_q, max_d, may_d;
  flags_t            s11_fl_q, fl_d;

  logic [NUM_W-1:0]  dv_numx_q [0:DIV_STAGES-1];
  logic [NUM_W-1:0]  dv_numy_q [0:DIV_STAGES-1];
  logic [DEN_W-1:0]  dv_den_q  [0:DIV_STAGES-1];
  flags_t            dv_fl_q   [0:DIV_STAGES];
  logic [DEN_W-1:0]  dv_rx_q   [1:DIV_STAGES];
  logic [DEN_W-1:0]  dv_ry_q   [1:DIV_STAGES];
  logic [QUO_W-1:0]  dv_qx_q   [1:DIV_STAGES];
  logic [QUO_W-1:0]  dv_qy_q   [1:DIV_STAGES];
  logic              dv_ovx_q  [1:DIV_STAGES];
  logic              dv_ovy_q  [1:DIV_STAGES];
  logic [DEN_W-1:0]  dv_rx_d   [0:DIV_STAGES-1];
  logic [DEN_W-1:0]  dv_ry_d   [0:DIV_STAGES-1];
  logic [QUO_W-1:0]  dv_qx_d   [0:DIV_STAGES-1];
  logic [QUO_W-1:0]  dv_qy_d   [0:DIV_STAGES-1];
  logic              dv_ovx_d  [0:DIV_STAGES-1];
  logic              dv_ovy_d  [0:DIV_STAGES-1];

  out_t res_q, res_d;

  // front end: magnitudes, squares and direction compares
  always_comb begin
    logic [AXIS_BITS-1:0]       xu;
    logic [AXIS_BITS-1:0]       yu;
    logic [MAG_W-1:0]           ax;
    logic [MAG_W-1:0]           ay;
    logic [SLOPE_W+MAG_W-1:0]   sax;
    logic [SLOPE_W+MAG_W-1:0]   say;
    logic                       cmp_v;
    logic                       cmp_h;
    xu    = item_i.axis_x;
    yu    = item_i.axis_y;
    ax    = xu[AXIS_BITS-1] ? (~xu + 1'b1) : xu;
    ay    = yu[AXIS_BITS-1] ? (~yu + 1'b1) : yu;
    sax   = SLOPE_Q16 * ax;
    say   = SLOPE_Q16 * ay;
    cmp_v = {ay, 16'h0000} > sax;
    cmp_h = {ax, 16'h0000} > say;
    side_d.neg_x     = xu[AXIS_BITS-1];
    side_d.neg_y     = yu[AXIS_BITS-1];
    side_d.mag_x     = ax;
    side_d.mag_y     = ay;
    side_d.dir.up    = yu[AXIS_BITS-1] & cmp_v;
    side_d.dir.down  = ~yu[AXIS_BITS-1] & cmp_v;
    side_d.dir.right = (~xu[AXIS_BITS-1] && ax != '0) & cmp_h;
    side_d.dir.left  = ~(~xu[AXIS_BITS-1] && ax != '0) & cmp_h;
    sqx_d = ax * ax;
    sqy_d = ay * ay;
  end

  // square root, two result bits per stage
  always_comb begin
    sqrt_t cur;
    int    k;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        cur = '0;
      end else begin
        cur = sq_st_q[s];
      end
      for (int j = 0; j < 2; j++) begin
        k = ROOT_W - 1 - 2 * s - j;
        if (k >= 0) begin
          cur = sqrt_step(cur, sq_n_q[s][2*k +: 2]);
        end
      end
      sq_st_d[s] = cur;
    end
  end

  // zone test, scale factor operands
  always_comb begin
    logic [ROOT_W-1:0] m;
    logic [DENF_W-1:0] denf;
    side_t             sd;
    m          = sq_st_q[SQRT_STAGES].root;
    sd         = sq_side_q[SQRT_STAGES];
    denf       = DENF_BASE - DENF_W'(dz_q);
    diff_d     = m - ROOT_W'(dz_q);
    den_d      = m * denf;
    max_d      = MA_W'({sd.mag_x, {(AXIS_BITS-1){1'b0}}}) - MA_W'(sd.mag_x);
    may_d      = MA_W'({sd.mag_y, {(AXIS_BITS-1){1'b0}}}) - MA_W'(sd.mag_y);
    fl_d.outside = m >= ROOT_W'(dz_q);
    fl_d.zero    = m == '0;
    fl_d.neg_x   = sd.neg_x;
    fl_d.neg_y   = sd.neg_y;
    fl_d.dir     = sd.dir;
  end

  // restoring division, two quotient bits per stage
  always_comb begin
    logic [DEN_W-1:0] rx;
    logic [DEN_W-1:0] ry;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
    logic             ox;
    logic             oy;
    logic [DEN_W:0]   st;
    int               k;
    for (int s = 0; s < DIV_STAGES; s++) begin
      den = dv_den_q[s];
      if (s == 0) begin
        rx = DEN_W'(dv_numx_q[s] >> QUO_W);
        ry = DEN_W'(dv_numy_q[s] >> QUO_W);
        ox = rx >= den;
        oy = ry >= den;
        qx = '0;
        qy = '0;
      end else begin
        rx = dv_rx_q[s];
        ry = dv_ry_q[s];
        ox = dv_ovx_q[s];
        oy = dv_ovy_q[s];
        qx = dv_qx_q[s];
        qy = dv_qy_q[s];
      end
      for (int j = 0; j < 2; j++) begin
        k = QUO_W - 1 - 2 * s - j;
        if (k >= 0) begin
          st    = div_step(rx, dv_numx_q[s][k], den);
          qx[k] = st[DEN_W];
          rx    = st[DEN_W-1:0];
          st    = div_step(ry, dv_numy_q[s][k], den);
          qy[k] = st[DEN_W];
          ry    = st[DEN_W-1:0];
        end
      end
      dv_rx_d[s]  = rx;
      dv_ry_d[s]  = ry;
      dv_qx_d[s]  = qx;
      dv_qy_d[s]  = qy;
      dv_ovx_d[s] = ox;
      dv_ovy_d[s] = oy;
    end
  end

  // saturate, apply sign, mask inside the zone
  always_comb begin
    flags_t fl;
    logic   scale_en;
    fl       = dv_fl_q[DIV_STAGES];
    scale_en = fl.outside & ~fl.zero;
    res_d.scaled_x = scale_en ?
        sat_axis(fl.neg_x, dv_ovx_q[DIV_STAGES], dv_qx_q[DIV_STAGES]) : '0;
    res_d.scaled_y = scale_en ?
        sat_axis(fl.neg_y, dv_ovy_q[DIV_STAGES], dv_qy_q[DIV_STAGES]) : '0;
    res_d.outside_zone = fl.outside;
    res_d.dir_up       = fl.outside & fl.dir.up;
    res_d.dir_down     = fl.outside & fl.dir.down;
    res_d.dir_left     = fl.outside & fl.dir.left;
    res_d.dir_right    = fl.outside & fl.dir.right;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q    <= DZ_RESET;
      s1_v_q  <= 1'b0;
      sq_v_q  <= '0;
      s11_v_q <= 1'b0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dz_q <= cfg_wdata_i;
      end
      s1_v_q  <= start_i & ~busy_o;
      sq_v_q  <= {sq_v_q[SQRT_STAGES-1:0], s1_v_q};
      s11_v_q <= sq_v_q[SQRT_STAGES];
      dv_v_q  <= {dv_v_q[DIV_STAGES-1:0], s11_v_q};
      out_v_q <= dv_v_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q    <= side_d;
    s1_sqx_q     <= sqx_d;
    s1_sqy_q     <= sqy_d;
    sq_n_q[0]    <= s1_sqx_q + s1_sqy_q;
    sq_side_q[0] <= s1_side_q;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      sq_st_q[s+1]   <= sq_st_d[s];
      sq_side_q[s+1] <= sq_side_q[s];
      if (s + 1 < SQRT_STAGES) begin
        sq_n_q[s+1] <= sq_n_q[s];
      end
    end
    s11_diff_q <= diff_d;
    s11_den_q  <= den_d;
    s11_max_q  <= max_d;
    s11_may_q  <= may_d;
    s11_fl_q   <= fl_d;
    dv_numx_q[0] <= s11_max_q * s11_diff_q;
    dv_numy_q[0] <= s11_may_q * s11_diff_q;
    dv_den_q[0]  <= s11_den_q;
    dv_fl_q[0]   <= s11_fl_q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      dv_rx_q[s+1]  <= dv_rx_d[s];
      dv_ry_q[s+1]  <= dv_ry_d[s];
      dv_qx_q[s+1]  <= dv_qx_d[s];
      dv_qy_q[s+1]  <= dv_qy_d[s];
      dv_ovx_q[s+1] <= dv_ovx_d[s];
      dv_ovy_q[s+1] <= dv_ovy_d[s];
      dv_fl_q[s+1]  <= dv_fl_q[s];
      if (s + 1 < DIV_STAGES) begin
        dv_numx_q[s+1] <= dv_numx_q[s];
        dv_numy_q[s+1] <= dv_numy_q[s];
        dv_den_q[s+1]  <= dv_den_q[s];
      end
    end
    res_q <= res_d;
  end

  assign busy_o   = 1'b0;
  assign valid_o  = out_v_q;
  assign result_o = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY valid_o)
    else $error("item result missing at fixed latency");

  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.outside_zone |-> result_o.scaled_x == '0 &&
      result_o.scaled_y == '0 && !result_o.dir_up && !result_o.dir_down &&
      !result_o.dir_left && !result_o.dir_right)
    else $error("nonzero result inside dead zone");

  a_dir_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(result_o.dir_up && result_o.dir_down) &&
      !(result_o.dir_left && result_o.dir_right))
    else $error("opposite directions set together");

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[DIV_STAGES] && !dv_fl_q[DIV_STAGES].neg_x |=> !result_o.scaled_x[AXIS_BITS-1])
    else $error("positive axis gave negative scaled value");

endmodule
